[rtl/twpw_pkg.sv]
// ---------------------------------------------------------------------------
// twpw_pkg
// Shared types and constants for the two-level page walk block with its TLB.
// ---------------------------------------------------------------------------
`default_nettype none

package twpw_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned VPN_W   = 20;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned OFF_W   = 12;

  // result kinds
  localparam logic [1:0] KIND_PHYS       = 2'd0;
  localparam logic [1:0] KIND_READ       = 2'd1;
  localparam logic [1:0] KIND_DIR_FAULT  = 2'd2;
  localparam logic [1:0] KIND_PAGE_FAULT = 2'd3;

  // item opcodes
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_READ_DATA = 1'b1;

  // register index on the configuration port
  localparam logic REG_PAGING   = 1'b0;
  localparam logic REG_DIR_BASE = 1'b1;

  typedef enum logic [2:0] {
    RES_PASS,
    RES_HIT,
    RES_DIR_READ,
    RES_TBL_READ,
    RES_DIR_FAULT,
    RES_PAGE_FAULT,
    RES_WALK_PHYS
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     tlb_read;
    logic     set_pending;
    logic     fill;
    logic     load_out;
    res_sel_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic opcode;
    logic present;
    logic any_hit;
    logic tlb_full;
    logic rem_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/two_level_page_walk_with_tlb.sv]
// ---------------------------------------------------------------------------
// two_level_page_walk_with_tlb
// 32-bit two-level page translation with a fully associative TLB.
// ---------------------------------------------------------------------------
// Input items carry either a translate request (opcode 0) or a directory or
// table entry word returned from memory (opcode 1). Each item gives at most
// one output item: a physical address, a memory read request, a directory
// fault or a page fault. A miss issues a directory read; the returned words
// come back in as items and drive the walk to its table read and result.
// A translate with paging on does a tag compare, then a priority select and
// frame memory read. A present table entry fills the TLB. When the TLB is
// full the victim slot comes from a reciprocal remainder unit started with
// the walk; it is ready long before the table entry can return, so the fill
// does not wait. The output register lets a new item in while a result
// waits; if the receiver stalls, the block holds in its emit step and stops
// taking items. Reset clears the TLB valid bits, the walk phase and both
// registers (paging off, directory base zero). Registers sit at 0x0 and 0x4
// on the configuration port and are to be written by the user only while
// the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module two_level_page_walk_with_tlb #(
  parameter int unsigned TLB_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [twpw_pkg::ADDR_W-1:0]   linear_address_i,
  input  wire logic [twpw_pkg::ADDR_W-1:0]   read_data_i,
  // item output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [1:0]                    kind_o,
  output logic      [twpw_pkg::ADDR_W-1:0]   address_out_o,
  output logic                               tlb_hit_o,
  // configuration
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [2:0]                    paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  output logic      [31:0]                   prdata_o,
  output logic                               pready_o
);

  localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);

  logic                         paging_q;
  logic [twpw_pkg::FRAME_W-1:0] dir_base_q;
  logic                         reg_wr;
  twpw_pkg::ctrl_cmd_t          cmd;
  twpw_pkg::dp_status_t         status;

  assign pready_o = 1'b1;
  assign reg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q   <= 1'b0;
      dir_base_q <= '0;
    end else if (reg_wr) begin
      case (paddr_i[2])
        twpw_pkg::REG_PAGING:   paging_q   <= pwdata_i[0];
        twpw_pkg::REG_DIR_BASE: dir_base_q <= pwdata_i[twpw_pkg::FRAME_W-1:0];
        default: begin
          paging_q <= paging_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr_i[2])
      twpw_pkg::REG_PAGING:   prdata_o = {31'd0, paging_q};
      twpw_pkg::REG_DIR_BASE: prdata_o = {12'd0, dir_base_q};
      default:                prdata_o = '0;
    endcase
  end

  twpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .paging_i   (paging_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  twpw_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .linear_address_i (linear_address_i),
    .read_data_i      (read_data_i),
    .dir_base_i       (dir_base_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .address_out_o    (address_out_o),
    .tlb_hit_o        (tlb_hit_o)
  );

endmodule

`default_nettype wire

[rtl/twpw_rem.sv]
// ---------------------------------------------------------------------------
// twpw_rem
// Remainder of a 32-bit address by a constant modulus, by reciprocal multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module twpw_rem #(
  parameter int unsigned MODULUS = 63,
  parameter int unsigned REM_W   = 6
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [twpw_pkg::ADDR_W-1:0]      value_i,
  output logic      [REM_W-1:0]                 rem_o,
  output logic                                  done_o
);

  localparam int unsigned AW    = twpw_pkg::ADDR_W;
  // q = (x * ceil(2^SH / m)) >> SH is exact for every 32-bit x when m <= 2^REM_W
  localparam int unsigned SH    = AW + REM_W;
  localparam int unsigned RCP_W = 34;
  localparam int unsigned PRD_W = AW + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((68'd1 << SH) + 68'(MODULUS) - 68'd1) / 68'(MODULUS));
  localparam logic [REM_W-1:0] MOD_C = REM_W'(MODULUS);

  logic [AW-1:0]    value_q;
  logic [PRD_W-1:0] prod;
  logic [REM_W-1:0] quot_lo_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] rem_d;
  logic [1:0]       busy_q;
  logic             done_q;

  assign prod  = PRD_W'(value_q) * PRD_W'(RECIP);
  // remainder is below 2^REM_W, so only the low bits of x - q*m are needed
  assign rem_d = value_q[REM_W-1:0] - quot_lo_q * MOD_C;

  assign rem_o  = rem_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 2'b01;
      done_q <= 1'b0;
    end else begin
      busy_q <= {busy_q[0], 1'b0};
      if (busy_q[1]) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= value_i;
    end
    if (busy_q[0]) begin
      quot_lo_q <= prod[SH +: REM_W];
    end
    if (busy_q[1]) begin
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

[rtl/twpw_tlb.sv]
// ---------------------------------------------------------------------------
// twpw_tlb
// Fully associative TLB: tag cells with registered match vector, frame memory.
// ---------------------------------------------------------------------------
`default_nettype none

module twpw_tlb #(
  parameter int unsigned TLB_ENTRIES = 64,
  parameter int unsigned IDX_W       = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [twpw_pkg::VPN_W-1:0]    vpn_i,
  input  wire logic                          rd_en_i,
  input  wire logic                          fill_i,
  input  wire logic [twpw_pkg::VPN_W-1:0]    fill_tag_i,
  input  wire logic [twpw_pkg::FRAME_W-1:0]  fill_frame_i,
  input  wire logic [IDX_W-1:0]              victim_i,
  output logic                               any_hit_o,
  output logic                               full_o,
  output logic      [twpw_pkg::FRAME_W-1:0]  frame_o
);

  logic [TLB_ENTRIES-1:0]       valid_q;
  logic [TLB_ENTRIES-1:0]       match_q;
  logic [twpw_pkg::VPN_W-1:0]   tag_q [TLB_ENTRIES];
  logic [twpw_pkg::FRAME_W-1:0] frame_mem [TLB_ENTRIES];
  logic [twpw_pkg::FRAME_W-1:0] frame_rd_q;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [IDX_W-1:0]             fill_idx;

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit_o = |match_q;
  assign full_o    = &valid_q;
  assign fill_idx  = full_o ? victim_i : free_idx;
  assign frame_o   = frame_rd_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_q[i] <= valid_q[i] && (tag_q[i] == vpn_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fill_i) begin
      valid_q[fill_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i) begin
      tag_q[fill_idx] <= fill_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i) begin
      frame_mem[fill_idx] <= fill_frame_i;
    end
    if (rd_en_i) begin
      frame_rd_q <= frame_mem[hit_idx];
    end
  end

endmodule

`default_nettype wire

[rtl/twpw_dp.sv]
// ---------------------------------------------------------------------------
// twpw_dp
// Datapath: item registers, pending walk address, TLB, victim unit, result.
// ---------------------------------------------------------------------------
`default_nettype none

module twpw_dp #(
  parameter int unsigned TLB_ENTRIES = 64,
  parameter int unsigned IDX_W       = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire twpw_pkg::ctrl_cmd_t            cmd_i,
  output twpw_pkg::dp_status_t                status_o,
  input  wire logic                           opcode_i,
  input  wire logic [twpw_pkg::ADDR_W-1:0]    linear_address_i,
  input  wire logic [twpw_pkg::ADDR_W-1:0]    read_data_i,
  input  wire logic [twpw_pkg::FRAME_W-1:0]   dir_base_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [1:0]                     kind_o,
  output logic      [twpw_pkg::ADDR_W-1:0]    address_out_o,
  output logic                                tlb_hit_o
);

  localparam int unsigned OFF_W = twpw_pkg::OFF_W;
  localparam int unsigned AW    = twpw_pkg::ADDR_W;

  logic                         item_opcode_q;
  logic [AW-1:0]                item_lin_q;
  logic [AW-1:0]                item_data_q;
  logic [AW-1:0]                pending_q;
  logic                         out_valid_q;
  logic [1:0]                   kind_q;
  logic [AW-1:0]                addr_q;
  logic                         hit_q;
  logic [1:0]                   kind_d;
  logic [AW-1:0]                addr_d;
  logic                         hit_d;
  logic                         any_hit;
  logic                         tlb_full;
  logic [twpw_pkg::FRAME_W-1:0] frame_rd;
  logic [IDX_W-1:0]             victim;
  logic                         rem_done;

  twpw_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_tlb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vpn_i        (item_lin_q[AW-1:OFF_W]),
    .rd_en_i      (cmd_i.tlb_read),
    .fill_i       (cmd_i.fill),
    .fill_tag_i   (pending_q[AW-1:OFF_W]),
    .fill_frame_i (item_data_q[AW-1:OFF_W]),
    .victim_i     (victim),
    .any_hit_o    (any_hit),
    .full_o       (tlb_full),
    .frame_o      (frame_rd)
  );

  // victim slot when full: pending address mod (entries - 1)
  twpw_rem #(
    .MODULUS (TLB_ENTRIES - 1),
    .REM_W   (IDX_W)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.set_pending),
    .value_i (item_lin_q),
    .rem_o   (victim),
    .done_o  (rem_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_opcode_q <= opcode_i;
      item_lin_q    <= linear_address_i;
      item_data_q   <= read_data_i;
    end
    if (cmd_i.set_pending) begin
      pending_q <= item_lin_q;
    end
  end

  always_comb begin
    kind_d = twpw_pkg::KIND_PHYS;
    addr_d = item_lin_q;
    hit_d  = 1'b0;
    case (cmd_i.sel)
      twpw_pkg::RES_PASS: begin
        addr_d = item_lin_q;
      end
      twpw_pkg::RES_HIT: begin
        addr_d = {frame_rd, item_lin_q[OFF_W-1:0]};
        hit_d  = 1'b1;
      end
      twpw_pkg::RES_DIR_READ: begin
        kind_d = twpw_pkg::KIND_READ;
        addr_d = {dir_base_i, pending_q[AW-1:22], 2'b00};
      end
      twpw_pkg::RES_TBL_READ: begin
        kind_d = twpw_pkg::KIND_READ;
        addr_d = {item_data_q[AW-1:OFF_W], pending_q[21:OFF_W], 2'b00};
      end
      twpw_pkg::RES_DIR_FAULT: begin
        kind_d = twpw_pkg::KIND_DIR_FAULT;
        addr_d = pending_q;
      end
      twpw_pkg::RES_PAGE_FAULT: begin
        kind_d = twpw_pkg::KIND_PAGE_FAULT;
        addr_d = pending_q;
      end
      twpw_pkg::RES_WALK_PHYS: begin
        addr_d = {item_data_q[AW-1:OFF_W], pending_q[OFF_W-1:0]};
      end
      default: begin
        addr_d = item_lin_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      hit_q  <= hit_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign address_out_o = addr_q;
  assign tlb_hit_o     = hit_q;

  assign status_o.opcode   = item_opcode_q;
  assign status_o.present  = item_data_q[0];
  assign status_o.any_hit  = any_hit;
  assign status_o.tlb_full = tlb_full;
  assign status_o.rem_done = rem_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[rtl/twpw_ctrl.sv]
// ---------------------------------------------------------------------------
// twpw_ctrl
// Controller: item sequencing and the page walk phase.
// ---------------------------------------------------------------------------
`default_nettype none

module twpw_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  paging_i,
  input  wire twpw_pkg::dp_status_t  status_i,
  output twpw_pkg::ctrl_cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DIR   = 2'd1;
  localparam logic [1:0] PH_TABLE = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [1:0]         phase_q, phase_d;
  twpw_pkg::res_sel_e sel_q, sel_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d           = state_q;
    phase_d           = phase_q;
    sel_d             = sel_q;
    cmd_o.capture     = 1'b0;
    cmd_o.tlb_read    = 1'b0;
    cmd_o.set_pending = 1'b0;
    cmd_o.fill        = 1'b0;
    cmd_o.load_out    = 1'b0;
    cmd_o.sel         = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        if (status_i.opcode == twpw_pkg::OP_TRANSLATE) begin
          // a translate request drops any walk in flight
          phase_d = PH_IDLE;
          if (paging_i) begin
            state_d = S_LOOK;
          end else begin
            sel_d   = twpw_pkg::RES_PASS;
            state_d = S_EMIT;
          end
        end else begin
          case (phase_q)
            PH_DIR: begin
              state_d = S_EMIT;
              if (status_i.present) begin
                sel_d   = twpw_pkg::RES_TBL_READ;
                phase_d = PH_TABLE;
              end else begin
                sel_d   = twpw_pkg::RES_DIR_FAULT;
                phase_d = PH_IDLE;
              end
            end
            PH_TABLE: begin
              phase_d = PH_IDLE;
              if (status_i.present) begin
                state_d = S_FILL;
              end else begin
                sel_d   = twpw_pkg::RES_PAGE_FAULT;
                state_d = S_EMIT;
              end
            end
            default: begin
              // read data with no walk pending gives no item
              phase_d = PH_IDLE;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LOOK: begin
        state_d = S_FIND;
      end
      S_FIND: begin
        cmd_o.tlb_read = 1'b1;
        state_d        = S_EMIT;
        if (status_i.any_hit) begin
          sel_d = twpw_pkg::RES_HIT;
        end else begin
          sel_d             = twpw_pkg::RES_DIR_READ;
          cmd_o.set_pending = 1'b1;
          phase_d           = PH_DIR;
        end
      end
      S_FILL: begin
        // when full the victim slot must be ready first
        if (!status_i.tlb_full || status_i.rem_done) begin
          cmd_o.fill = 1'b1;
          sel_d      = twpw_pkg::RES_WALK_PHYS;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      sel_q   <= twpw_pkg::RES_PASS;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      sel_q   <= sel_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded while output register still full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fill |-> (!status_i.tlb_full || status_i.rem_done))
    else $error("tlb fill with no victim slot ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DEC))
    else $error("accepted item not decoded next cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_pending |=> (phase_q == PH_DIR))
    else $error("walk started without directory phase");

endmodule

`default_nettype wire
